// File: src/i2cm_pkg.sv
`timescale 1ns / 1ps
// i2cm_pkg: shared types and constants for the I2C master bit engine.
// No dependencies; used by every file under src.
package i2cm_pkg;

  localparam int unsigned DATA_W     = 8;
  localparam int unsigned BIT_CNT_W  = 3;
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;

  localparam logic [DATA_W-1:0] ACK_TIMEOUT_RST = 8'd100;

  // Command codes
  localparam logic [2:0] OP_START = 3'd0;
  localparam logic [2:0] OP_STOP  = 3'd1;
  localparam logic [2:0] OP_WRITE = 3'd2;
  localparam logic [2:0] OP_READ  = 3'd3;
  localparam logic [2:0] OP_WAIT  = 3'd4;

  // Register index of ack_timeout (paddr[2])
  localparam logic REG_ACK_TIMEOUT = 1'b0;

  typedef enum logic [14:0] {
    PH_IDLE    = 15'b000_0000_0000_0001,
    PH_ST_A    = 15'b000_0000_0000_0010,
    PH_ST_B    = 15'b000_0000_0000_0100,
    PH_SP_A    = 15'b000_0000_0000_1000,
    PH_SP_B    = 15'b000_0000_0001_0000,
    PH_SP_C    = 15'b000_0000_0010_0000,
    PH_WR_SET  = 15'b000_0000_0100_0000,
    PH_WR_HIGH = 15'b000_0000_1000_0000,
    PH_END     = 15'b000_0001_0000_0000,
    PH_RD_LOW  = 15'b000_0010_0000_0000,
    PH_RD_HIGH = 15'b000_0100_0000_0000,
    PH_AK_SET  = 15'b000_1000_0000_0000,
    PH_AK_HIGH = 15'b001_0000_0000_0000,
    PH_WT_LOW  = 15'b010_0000_0000_0000,
    PH_WT_HIGH = 15'b100_0000_0000_0000
  } phase_t;

  // One tick's result
  typedef struct packed {
    logic              ack_missing;
    logic [DATA_W-1:0] rd_data;
    logic              done_res;
    logic              busy_res;
    logic              sda_out;
    logic              scl;
  } res_t;

endpackage

// File: src/i2cm_cfg.sv
`timescale 1ns / 1ps
// i2cm_cfg: APB register block holding ack_timeout.
// Depends on i2cm_pkg.
module i2cm_cfg (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [i2cm_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [i2cm_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [i2cm_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready,
  output logic [i2cm_pkg::DATA_W-1:0]         ack_timeout
);

  logic hit;

  assign pready = 1'b1;
  assign hit    = (paddr[2] == i2cm_pkg::REG_ACK_TIMEOUT);

  always_ff @(posedge clk) begin
    if (rst) begin
      ack_timeout <= i2cm_pkg::ACK_TIMEOUT_RST;
    end else if (psel && penable && pwrite && pready && hit) begin
      ack_timeout <= pwdata[i2cm_pkg::DATA_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (hit) begin
      prdata[i2cm_pkg::DATA_W-1:0] = ack_timeout;
    end
  end

endmodule

// File: src/i2cm_core.sv
`timescale 1ns / 1ps
// i2cm_core: bus phase sequencer; one phase per accepted tick.
// Depends on i2cm_pkg.
module i2cm_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             step,
  input  logic                             cmd_valid,
  input  logic [2:0]                       op,
  input  logic [i2cm_pkg::DATA_W-1:0]      wr_data,
  input  logic                             send_ack,
  input  logic                             sda_in,
  input  logic [i2cm_pkg::DATA_W-1:0]      ack_timeout,
  output i2cm_pkg::res_t                   res
);

  i2cm_pkg::phase_t                 phase, phase_next, ph_cmd;
  logic [i2cm_pkg::BIT_CNT_W-1:0]   bit_count, bit_count_next;
  logic [i2cm_pkg::DATA_W-1:0]      shift_byte, shift_byte_next, shift_cmd;
  logic [i2cm_pkg::DATA_W-1:0]      poll_count, poll_count_next, poll_inc;
  logic                             scl_level, scl_level_next;
  logic                             sda_level, sda_level_next;
  logic                             ack_choice, ack_choice_next;
  logic [i2cm_pkg::DATA_W-1:0]      rd_hold, rd_hold_next;
  logic                             miss_flag, miss_flag_next;
  logic                             done;

  always_comb begin
    ph_cmd           = phase;
    shift_cmd        = shift_byte;
    bit_count_next   = bit_count;
    poll_count_next  = poll_count;
    ack_choice_next  = ack_choice;
    miss_flag_next   = miss_flag;
    scl_level_next   = scl_level;
    sda_level_next   = sda_level;
    rd_hold_next     = rd_hold;
    done             = 1'b0;
    poll_inc         = poll_count;

    // command decode, only from idle
    if (phase == i2cm_pkg::PH_IDLE && cmd_valid && op <= i2cm_pkg::OP_WAIT) begin
      miss_flag_next = 1'b0;
      unique case (op)
        i2cm_pkg::OP_START: ph_cmd = i2cm_pkg::PH_ST_A;
        i2cm_pkg::OP_STOP:  ph_cmd = i2cm_pkg::PH_SP_A;
        i2cm_pkg::OP_WRITE: begin
          ph_cmd         = i2cm_pkg::PH_WR_SET;
          shift_cmd      = wr_data;
          bit_count_next = '0;
        end
        i2cm_pkg::OP_READ: begin
          ph_cmd          = i2cm_pkg::PH_RD_LOW;
          shift_cmd       = '0;
          bit_count_next  = '0;
          ack_choice_next = send_ack;
        end
        default: begin
          ph_cmd          = i2cm_pkg::PH_WT_LOW;
          poll_count_next = '0;
        end
      endcase
    end

    shift_byte_next = shift_cmd;
    phase_next      = ph_cmd;

    unique case (ph_cmd)
      i2cm_pkg::PH_ST_A: begin
        scl_level_next = 1'b1;
        sda_level_next = 1'b1;
        phase_next     = i2cm_pkg::PH_ST_B;
      end
      i2cm_pkg::PH_ST_B: begin
        sda_level_next = 1'b0;
        phase_next     = i2cm_pkg::PH_END;
      end
      i2cm_pkg::PH_SP_A: begin
        scl_level_next = 1'b0;
        sda_level_next = 1'b0;
        phase_next     = i2cm_pkg::PH_SP_B;
      end
      i2cm_pkg::PH_SP_B: begin
        scl_level_next = 1'b1;
        phase_next     = i2cm_pkg::PH_SP_C;
      end
      i2cm_pkg::PH_SP_C: begin
        sda_level_next = 1'b1;
        done           = 1'b1;
        phase_next     = i2cm_pkg::PH_IDLE;
      end
      i2cm_pkg::PH_WR_SET: begin
        scl_level_next  = 1'b0;
        sda_level_next  = shift_cmd[i2cm_pkg::DATA_W-1];
        shift_byte_next = {shift_cmd[i2cm_pkg::DATA_W-2:0], 1'b0};
        phase_next      = i2cm_pkg::PH_WR_HIGH;
      end
      i2cm_pkg::PH_WR_HIGH: begin
        scl_level_next = 1'b1;
        if (&bit_count_next) begin
          bit_count_next = '0;
          phase_next     = i2cm_pkg::PH_END;
        end else begin
          bit_count_next = bit_count_next + 1'b1;
          phase_next     = i2cm_pkg::PH_WR_SET;
        end
      end
      i2cm_pkg::PH_END: begin
        scl_level_next = 1'b0;
        done           = 1'b1;
        phase_next     = i2cm_pkg::PH_IDLE;
      end
      i2cm_pkg::PH_RD_LOW: begin
        scl_level_next = 1'b0;
        sda_level_next = 1'b1;
        phase_next     = i2cm_pkg::PH_RD_HIGH;
      end
      i2cm_pkg::PH_RD_HIGH: begin
        scl_level_next  = 1'b1;
        shift_byte_next = {shift_cmd[i2cm_pkg::DATA_W-2:0], sda_in};
        if (&bit_count_next) begin
          rd_hold_next   = {shift_cmd[i2cm_pkg::DATA_W-2:0], sda_in};
          bit_count_next = '0;
          phase_next     = i2cm_pkg::PH_AK_SET;
        end else begin
          bit_count_next = bit_count_next + 1'b1;
          phase_next     = i2cm_pkg::PH_RD_LOW;
        end
      end
      i2cm_pkg::PH_AK_SET: begin
        scl_level_next = 1'b0;
        sda_level_next = ~ack_choice_next;
        phase_next     = i2cm_pkg::PH_AK_HIGH;
      end
      i2cm_pkg::PH_AK_HIGH: begin
        scl_level_next = 1'b1;
        phase_next     = i2cm_pkg::PH_END;
      end
      i2cm_pkg::PH_WT_LOW: begin
        scl_level_next = 1'b0;
        sda_level_next = 1'b1;
        phase_next     = i2cm_pkg::PH_WT_HIGH;
      end
      i2cm_pkg::PH_WT_HIGH: begin
        scl_level_next = 1'b1;
        if (!sda_in) begin
          phase_next = i2cm_pkg::PH_END;
        end else begin
          poll_inc        = poll_count_next + 1'b1;
          poll_count_next = poll_inc;
          if (poll_inc >= ack_timeout) begin
            miss_flag_next = 1'b1;
            phase_next     = i2cm_pkg::PH_SP_A;
          end else begin
            phase_next = i2cm_pkg::PH_WT_LOW;
          end
        end
      end
      default: phase_next = i2cm_pkg::PH_IDLE;
    endcase

    res.scl         = scl_level_next;
    res.sda_out     = sda_level_next;
    res.busy_res    = (phase_next != i2cm_pkg::PH_IDLE);
    res.done_res    = done;
    res.rd_data     = rd_hold_next;
    res.ack_missing = miss_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= i2cm_pkg::PH_IDLE;
      bit_count  <= '0;
      shift_byte <= '0;
      poll_count <= '0;
      scl_level  <= 1'b1;
      sda_level  <= 1'b1;
      ack_choice <= 1'b0;
      rd_hold    <= '0;
      miss_flag  <= 1'b0;
    end else if (step) begin
      phase      <= phase_next;
      bit_count  <= bit_count_next;
      shift_byte <= shift_byte_next;
      poll_count <= poll_count_next;
      scl_level  <= scl_level_next;
      sda_level  <= sda_level_next;
      ack_choice <= ack_choice_next;
      rd_hold    <= rd_hold_next;
      miss_flag  <= miss_flag_next;
    end
  end

`ifndef SYNTH
  // a completing command always leaves the engine idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    res.done_res |-> !res.busy_res)
    else $error("done with busy still set");

  // missing ACK is only flagged out of the ACK poll
  a_miss_src: assert property (@(posedge clk) disable iff (rst)
    $rose(miss_flag) |-> $past(phase) == i2cm_pkg::PH_WT_HIGH)
    else $error("ack_missing set outside ACK poll");

  // bit counter is only live inside a byte transfer
  a_bitcnt: assert property (@(posedge clk) disable iff (rst)
    bit_count != '0 |-> (phase == i2cm_pkg::PH_WR_SET || phase == i2cm_pkg::PH_WR_HIGH ||
                         phase == i2cm_pkg::PH_RD_LOW || phase == i2cm_pkg::PH_RD_HIGH))
    else $error("bit_count nonzero outside byte transfer");

  // ACK seen during poll ends the command on the next phase
  a_ack_end: assert property (@(posedge clk) disable iff (rst)
    step && phase == i2cm_pkg::PH_WT_HIGH && !sda_in |=> phase == i2cm_pkg::PH_END)
    else $error("ACK not honored");
`endif

endmodule

// File: src/i2c_master_bit_engine.sv
`timescale 1ns / 1ps
// I2C master bit engine top: APB config, phase sequencer, result register.
// A result appears on m_tdata in the cycle after its tick request is taken.
// Throughput: one tick per clock cycle, unless a held result is not taken (m_tready low).
// The result register frees s_tready whenever the held result is taken or empty.
// Reset (rst, synchronous): bus released, engine idle, ack_timeout back to 100.
// Depends on i2cm_pkg, i2cm_cfg, i2cm_core.
module i2c_master_bit_engine (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [15:0]                         s_tdata,  // wr_data[7:0], send_ack, sda_in
  input  logic [3:0]                          s_tuser,  // cmd_valid, op[2:0]
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // scl, sda_out, busy_res, done_res, rd_data[7:0], ack_missing
  output logic [15:0]                         m_tdata,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [i2cm_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [i2cm_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [i2cm_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready
);

  logic [i2cm_pkg::DATA_W-1:0] ack_timeout;
  i2cm_pkg::res_t              res, res_q;
  logic                        step;

  assign s_tready = !m_tvalid || m_tready;
  assign step     = s_tvalid && s_tready;

  i2cm_cfg u_cfg (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .ack_timeout (ack_timeout)
  );

  i2cm_core u_core (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .cmd_valid   (s_tuser[0]),
    .op          (s_tuser[3:1]),
    .wr_data     (s_tdata[7:0]),
    .send_ack    (s_tdata[8]),
    .sda_in      (s_tdata[9]),
    .ack_timeout (ack_timeout),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (step) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_q <= res;
    end
  end

  assign m_tdata = {3'b000, res_q};

endmodule
